// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker of the core (mmae_checker).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked around reset.
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mmae_pkg.sv -----
// Shared types and constants of the memory-to-memory ALU executor.
// No dependencies; used by the top level, the ALU and the checker.
`default_nettype none

package mmae_pkg;

  typedef enum logic [1:0] {
    ALU_SET,
    ALU_ADD,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

  localparam logic [3:0] CMD_SETC  = 4'd4;
  localparam logic [3:0] CMD_DIVC  = 4'd7;
  localparam logic [3:0] CMD_PRINT = 4'd8;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRINTED = 3'd1;
  localparam logic [2:0] ST_ADDR    = 3'd2;
  localparam logic [2:0] ST_UNDEF   = 3'd3;
  localparam logic [2:0] ST_DIV0    = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/core/memory_to_memory_alu_executor.sv -----
// Each request passes S_CHECK, S_SRC, S_DST, S_EXEC and S_FINISH; print and divide by
// zero skip S_EXEC, and address error, undefined command and halted go from S_CHECK to
// S_FINISH; multiply and divide run the 32-step ALU loop. One request in flight: a new
// one is taken only in S_IDLE, and a result stalled on m_tready holds the next request
// in its final state. Reset: synchronous; clears the halt flag, then a clearing pass
// writes zero to every memory cell, with s_tready low throughout.
`default_nettype none

module memory_to_memory_alu_executor #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // imm_value[31:0], source_cell[47:32], target_cell[63:48]
  input  logic [3:0]  s_tuser,  // cmd[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // print_value[31:0]
  output logic [2:0]  m_tuser   // status[2:0]
);
  import mmae_pkg::*;

  localparam int          AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [16:0] DEPTH_L = 17'(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SRC, S_DST, S_EXEC, S_FINISH
  } state_t;

  state_t      state;
  logic [3:0]  cmd;
  logic [31:0] imm;
  logic [15:0] src_cell;
  logic [15:0] dst_cell;
  logic [31:0] operand;
  logic        halted;
  logic [AW-1:0] clr_addr;
  logic [2:0]  status;
  logic [31:0] pval;

  logic [31:0]   mem [MEM_DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  alu_ctrl_t   alu_ctrl;
  logic        alu_done;
  logic [31:0] alu_result;

  logic is_undef;
  logic is_print;
  logic is_div;
  logic src_is_mem;
  logic addr_bad;

  assign is_undef   = cmd > CMD_PRINT;
  assign is_print   = cmd == CMD_PRINT;
  assign is_div     = alu_op_t'(cmd[1:0]) == ALU_DIV;
  assign src_is_mem = (cmd >= CMD_SETC) && (cmd <= CMD_DIVC);
  assign addr_bad   = ({1'b0, dst_cell} >= DEPTH_L) ||
                      (src_is_mem && ({1'b0, src_cell} >= DEPTH_L));

  assign s_tready = state == S_IDLE;

  assign rd_addr = (state == S_CHECK) ? src_cell[AW-1:0] : dst_cell[AW-1:0];
  assign wr_en   = (state == S_CLEAR) || ((state == S_EXEC) && alu_done);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : dst_cell[AW-1:0];
  assign wr_data = (state == S_CLEAR) ? 32'd0 : alu_result;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign alu_ctrl.start = (state == S_DST) && !is_print && !(is_div && (operand == 32'd0));
  assign alu_ctrl.op    = alu_op_t'(cmd[1:0]);

  mmae_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .a      (rd_data),
    .b      (operand),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd      <= s_tuser;
            imm      <= s_tdata[31:0];
            src_cell <= s_tdata[47:32];
            dst_cell <= s_tdata[63:48];
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          pval <= '0;
          if (halted) begin
            status <= ST_HALTED;
            state  <= S_FINISH;
          end else if (is_undef) begin
            status <= ST_UNDEF;
            halted <= 1'b1;
            state  <= S_FINISH;
          end else if (addr_bad) begin
            status <= ST_ADDR;
            halted <= 1'b1;
            state  <= S_FINISH;
          end else begin
            state <= S_SRC;
          end
        end
        S_SRC: begin
          operand <= src_is_mem ? rd_data : imm;
          state   <= S_DST;
        end
        S_DST: begin
          if (is_print) begin
            status <= ST_PRINTED;
            pval   <= rd_data;
            state  <= S_FINISH;
          end else if (is_div && (operand == 32'd0)) begin
            status <= ST_DIV0;
            halted <= 1'b1;
            state  <= S_FINISH;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (alu_done) begin
            status <= ST_DONE;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= pval;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmae_alu.sv -----
// Iterative ALU: set, add, shift-add multiply, restoring signed divide.
// Shared 33-bit adder/subtractor; depends on mmae_pkg.
`default_nettype none

module mmae_alu (
  input  logic                clk,
  input  logic                rst,
  input  mmae_pkg::alu_ctrl_t ctrl,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic                done,
  output logic [31:0]         result
);
  import mmae_pkg::*;

  typedef enum logic [2:0] {A_IDLE, A_ADD, A_MUL, A_DIV, A_FIX} astate_t;

  astate_t     astate;
  logic [31:0] acc;
  logic [31:0] breg;
  logic [31:0] creg;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        neg;

  logic [32:0] add_x;
  logic [32:0] add_y;
  logic        add_sub;
  logic [32:0] add_s;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (astate)
      A_ADD, A_MUL: begin
        add_x = {1'b0, acc};
        add_y = {1'b0, breg};
      end
      A_DIV: begin
        add_x   = {rem, creg[31]};
        add_y   = {1'b0, breg};
        add_sub = 1'b1;
      end
      A_FIX: begin
        add_y   = {1'b0, creg};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_s = add_x + (add_sub ? ~add_y : add_y) + {32'd0, add_sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (astate)
        A_IDLE: begin
          if (ctrl.start) begin
            unique case (ctrl.op)
              ALU_SET: begin
                result <= b;
                done   <= 1'b1;
              end
              ALU_ADD: begin
                acc    <= a;
                breg   <= b;
                astate <= A_ADD;
              end
              ALU_MUL: begin
                acc    <= '0;
                breg   <= a;
                creg   <= b;
                cnt    <= '0;
                astate <= A_MUL;
              end
              ALU_DIV: begin
                rem    <= '0;
                breg   <= b[31] ? (32'd0 - b) : b;
                creg   <= a[31] ? (32'd0 - a) : a;
                neg    <= a[31] ^ b[31];
                cnt    <= '0;
                astate <= A_DIV;
              end
            endcase
          end
        end
        A_ADD: begin
          result <= add_s[31:0];
          done   <= 1'b1;
          astate <= A_IDLE;
        end
        A_MUL: begin
          if (creg[0]) begin
            acc <= add_s[31:0];
          end
          breg <= {breg[30:0], 1'b0};
          creg <= {1'b0, creg[31:1]};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            result <= creg[0] ? add_s[31:0] : acc;
            done   <= 1'b1;
            astate <= A_IDLE;
          end
        end
        A_DIV: begin
          // quotient bits shift in as dividend bits shift out
          if (!add_s[32]) begin
            rem <= add_s[31:0];
          end else begin
            rem <= {rem[30:0], creg[31]};
          end
          creg <= {creg[30:0], ~add_s[32]};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            astate <= A_FIX;
          end
        end
        A_FIX: begin
          result <= neg ? add_s[31:0] : creg;
          done   <= 1'b1;
          astate <= A_IDLE;
        end
        default: astate <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmae_checker.sv -----
// Port-level checker for the memory-to-memory ALU executor, bound to the top.
// Depends on mmae_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mmae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);
  import mmae_pkg::*;

  logic err_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (m_tvalid && m_tready &&
                 (m_tuser == ST_ADDR || m_tuser == ST_UNDEF || m_tuser == ST_DIV0)) begin
      err_seen <= 1'b1;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `ASSERT_CLK(a_pval_zero, clk, rst, m_tvalid && (m_tuser != ST_PRINTED) |-> m_tdata == 32'd0, "print value nonzero on non-print result")
  `ASSERT_CLK(a_halt_sticky, clk, rst, m_tvalid && err_seen |-> m_tuser == ST_HALTED, "result after an error is not halted")
  `ASSERT_CLK_NORST(a_clear_busy, clk, rst |=> !s_tready, "request taken during memory clearing")

endmodule

bind memory_to_memory_alu_executor mmae_checker u_mmae_checker (.*);

`default_nettype wire
